// ----- rtl/ring_deque_marker_pop_assert.svh -----
// Assertion macros shared by the ring deque RTL.
// Depends on a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef RING_DEQUE_MARKER_POP_ASSERT_SVH
`define RING_DEQUE_MARKER_POP_ASSERT_SVH

// Condition holds at every edge outside reset.
`define RDMP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RDMP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RDMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rdmp_pkg.sv -----
// Package for the ring deque with marker-gated pop: request and status codes,
// field widths, stream packing widths and pipeline record types. No dependencies.
package rdmp_pkg;

    localparam int DEFAULT_DEPTH      = 256;
    localparam int DEFAULT_DATA_WIDTH = 32;

    // Field widths of one request and one result.
    localparam int REQ_W    = 2;
    localparam int ITEM_W   = 32;
    localparam int MARK_W   = 8;
    localparam int STATUS_W = 2;
    localparam int POPPED_W = 32;
    localparam int FRONT_W  = 8;
    localparam int OCC_W    = 9;

    // Stream packing: fields from the lowest bit up, padded to whole bytes.
    localparam int IN_TDATA_W  = ((ITEM_W + MARK_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = POPPED_W + FRONT_W + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_MARKED = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_REFUSED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Result of a request while the slot read is still in flight.
    typedef struct packed {
        t_status              status;
        logic                 pop_ok;
        logic [FRONT_W-1:0]   front;
        logic [OCC_W-1:0]     occ;
    } t_stage;

    // Finished result as presented on the output side.
    typedef struct packed {
        t_status              status;
        logic [POPPED_W-1:0]  popped;
        logic [FRONT_W-1:0]   front;
        logic [OCC_W-1:0]     occ;
    } t_result;

endpackage

// ----- rtl/ring_deque_marker_pop.sv -----
// Ring deque of work words with push back/front, pop front and marker-gated pop.
// An input transfer passes through stage one and then the output register.
// Throughput: one request per cycle unless the output stalls; each request does one slot
// read and at most one write; the output register lets a new transfer in while a result waits.
// Reset (i_rst_n low, synchronous) empties the deque and both stages; the slot store is
// not cleared, since a pop only ever reads slots that a push has written.
`include "ring_deque_marker_pop_assert.svh"

module ring_deque_marker_pop #(
    parameter int DEPTH      = rdmp_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = rdmp_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] item_data, [39:32] marker_index
    input  logic [rdmp_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] req_type
    input  logic [rdmp_pkg::REQ_W-1:0]      i_s_axis_tuser,
    // Result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] popped_data, [39:32] front_index, [48:40] occupancy, [55:49] zero
    output logic [rdmp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [rdmp_pkg::STATUS_W-1:0]   o_m_axis_tuser
);

    import rdmp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Marker compare width: wide enough for the raw marker and for a pointer.
    localparam int CMP_W = (PTR_W > MARK_W) ? PTR_W : MARK_W;

    // Ring pointer step forward, wrapping at DEPTH.
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Ring pointer step back, wrapping at zero.
    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // State: pointers, count, slot store
    // ---------------------------------------------------------------
    logic [PTR_W-1:0]      r_front;
    logic [PTR_W-1:0]      r_back;
    logic [CNT_W-1:0]      r_count;
    logic [DATA_WIDTH-1:0] r_slots [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Pipeline: stage one holds the decision plus the registered slot read,
    // the output register holds the finished result.
    logic    r_s1_valid;
    t_stage  r_s1;
    logic    r_out_valid;
    t_result r_out;

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    t_req                  req;
    logic [DATA_WIDTH-1:0] word;
    logic [MARK_W-1:0]     marker;

    assign req    = t_req'(i_s_axis_tuser);
    assign word   = DATA_WIDTH'(i_s_axis_tdata[ITEM_W-1:0]);
    assign marker = i_s_axis_tdata[ITEM_W +: MARK_W];

    // Handshake: stage one drains into the output register when that register
    // is empty or being taken; a new transfer enters when stage one frees up.
    logic s1_adv;
    logic in_acc;

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------------------------------------------------------
    // Marker test: refuse when front lies in the circular region from the
    // marker up to (not including) back. The marker is compared unwrapped.
    // ---------------------------------------------------------------
    logic [CMP_W-1:0] cmp_mk;
    logic [CMP_W-1:0] cmp_f;
    logic [CMP_W-1:0] cmp_b;
    logic             mk_block;

    assign cmp_mk = CMP_W'(marker);
    assign cmp_f  = CMP_W'(r_front);
    assign cmp_b  = CMP_W'(r_back);

    always_comb begin
        mk_block = 1'b0;
        if (cmp_mk <= cmp_b && cmp_f >= cmp_mk && cmp_f < cmp_b) begin
            mk_block = 1'b1;
        end
        if (cmp_b < cmp_mk && (cmp_f >= cmp_mk || cmp_f < cmp_b)) begin
            mk_block = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Next state and result for one request
    // ---------------------------------------------------------------
    logic [PTR_W-1:0] n_front;
    logic [PTR_W-1:0] n_back;
    logic [CNT_W-1:0] n_count;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    t_status          status;
    logic             pop_ok;
    logic             is_full;
    logic             is_empty;
    t_stage           n_s1;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        wr_en   = 1'b0;
        wr_addr = r_back;
        status  = ST_DONE;
        pop_ok  = 1'b0;
        unique case (req) inside
            REQ_PUSH_BACK: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_back;
                    n_back  = ptr_next(r_back);
                    n_count = r_count + 1'b1;
                end
            end
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = ptr_prev(r_front);
                    n_front = ptr_prev(r_front);
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_POP_MARKED: begin
                // Empty is checked before the marker.
                if (is_empty) begin
                    status = ST_EMPTY;
                end else if (req == REQ_POP_MARKED && mk_block) begin
                    status = ST_REFUSED;
                end else begin
                    pop_ok  = 1'b1;
                    n_front = ptr_next(r_front);
                    n_count = r_count - 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        n_s1.status = status;
        n_s1.pop_ok = pop_ok;
        n_s1.front  = FRONT_W'(n_front);
        n_s1.occ    = OCC_W'(n_count);
    end

    // ---------------------------------------------------------------
    // Slot store: at most one write and one read per accepted request. The read
    // always fetches the old front slot; stage one keeps it only on a pop.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (wr_en) begin
                r_slots[wr_addr] <= word;
            end
            r_rd_data <= r_slots[r_front];
        end
    end

    // ---------------------------------------------------------------
    // Control registers and pipeline
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
            // Stage one: fill on a transfer, drop once drained.
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            // Output register: fill from stage one, drop once transferred.
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out.status <= r_s1.status;
            r_out.popped <= r_s1.pop_ok ? POPPED_W'(r_rd_data) : '0;
            r_out.front  <= r_s1.front;
            r_out.occ    <= r_s1.occ;
        end
    end

    // ---------------------------------------------------------------
    // Output packing
    // ---------------------------------------------------------------
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.occ, r_out.front, r_out.popped};
    assign o_m_axis_tuser  = r_out.status;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `RDMP_ASSERT_IMPLIES(a_ptr_meet, (r_count == '0 || r_count == CNT_W'(DEPTH)), (r_front == r_back), "pointers differ while deque is empty or full")
    `RDMP_ASSERT_IMPLIES(a_ptr_apart, (r_count != '0 && r_count != CNT_W'(DEPTH)), (r_front != r_back), "pointers meet while deque is partly filled")
    `RDMP_ASSERT_NEXT(a_full_flag, (in_acc && is_full && (req == REQ_PUSH_BACK || req == REQ_PUSH_FRONT)), (r_s1.status == ST_FULL && r_count == CNT_W'(DEPTH)), "push into full deque not rejected")
    `RDMP_ASSERT_NEXT(a_pop_count, (in_acc && pop_ok), (r_s1.pop_ok && r_count == $past(r_count) - 1'b1), "successful pop did not lower the count")

endmodule
